FILE: sv/lpg_pkg.sv
// ----------------------------------------------------------------------------
// Line pixel generator package
// Shared codes, register indexes and the flag group passed from the walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

  localparam int CFG_W = 15;

  localparam logic [0:0] ACTION_LOAD = 1'b0;
  localparam logic [0:0] ACTION_STEP = 1'b1;

  localparam logic [0:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [0:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 15'd320;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 15'd200;

  typedef struct packed {
    logic busy;
    logic last;
  } point_flags_t;

endpackage

`default_nettype wire

FILE: sv/lpg_walker.sv
// ----------------------------------------------------------------------------
// Line walker
// Holds the line state and works out the point for the item in the input
// register: a load sets up deltas, directions and error, a step moves one point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpg_walker #(
  parameter int COORD_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         advance,
  input  wire  [0:0]                  action,
  input  wire  signed [COORD_BITS-1:0] start_x,
  input  wire  signed [COORD_BITS-1:0] start_y,
  input  wire  signed [COORD_BITS-1:0] end_x,
  input  wire  signed [COORD_BITS-1:0] end_y,
  input  wire  [7:0]                  color,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [7:0]                  pixel_color,
  output lpg_pkg::point_flags_t       flags
);

  localparam int C  = COORD_BITS;
  localparam int EW = COORD_BITS + 2;

  logic signed [C-1:0]  cur_x;
  logic signed [C-1:0]  cur_y;
  logic signed [C-1:0]  target_x;
  logic signed [C-1:0]  target_y;
  logic [C-1:0]         delta_x;
  logic [C-1:0]         delta_y;
  logic                 step_x_negative;
  logic                 step_y_negative;
  logic signed [EW-1:0] error_term;
  logic [7:0]           line_color;
  logic                 active;

  logic signed [C:0]    diff_x;
  logic signed [C:0]    diff_y;
  logic [C-1:0]         load_dx;
  logic [C-1:0]         load_dy;
  logic signed [EW-1:0] load_err;
  logic signed [EW:0]   e2;
  logic                 move_x;
  logic                 move_y;
  logic signed [EW-1:0] err_step;
  logic signed [C-1:0]  step_x;
  logic signed [C-1:0]  step_y;
  logic signed [C-1:0]  tgt_x;
  logic signed [C-1:0]  tgt_y;
  logic                 is_load;

  assign is_load = (action == lpg_pkg::ACTION_LOAD);

  always_comb begin
    diff_x   = $signed({end_x[C-1], end_x}) - $signed({start_x[C-1], start_x});
    diff_y   = $signed({end_y[C-1], end_y}) - $signed({start_y[C-1], start_y});
    load_dx  = diff_x[C] ? C'(-diff_x) : diff_x[C-1:0];
    load_dy  = diff_y[C] ? C'(-diff_y) : diff_y[C-1:0];
    load_err = $signed({2'b00, load_dx}) - $signed({2'b00, load_dy});

    e2     = {error_term, 1'b0};
    move_x = e2 > -$signed({3'b000, delta_y});
    move_y = e2 < $signed({3'b000, delta_x});

    err_step = error_term
             - (move_x ? $signed({2'b00, delta_y}) : $signed(EW'(0)))
             + (move_y ? $signed({2'b00, delta_x}) : $signed(EW'(0)));
    step_x = move_x ? (step_x_negative ? cur_x - C'(1) : cur_x + C'(1)) : cur_x;
    step_y = move_y ? (step_y_negative ? cur_y - C'(1) : cur_y + C'(1)) : cur_y;

    tgt_x = is_load ? end_x : target_x;
    tgt_y = is_load ? end_y : target_y;

    if (is_load) begin
      pixel_x     = start_x;
      pixel_y     = start_y;
      pixel_color = color;
      flags.busy  = 1'b1;
    end else if (active) begin
      pixel_x     = step_x;
      pixel_y     = step_y;
      pixel_color = line_color;
      flags.busy  = 1'b1;
    end else begin
      pixel_x     = '0;
      pixel_y     = '0;
      pixel_color = '0;
      flags.busy  = 1'b0;
    end
    flags.last = flags.busy && (pixel_x == tgt_x) && (pixel_y == tgt_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (advance) begin
      if (is_load) begin
        cur_x           <= start_x;
        cur_y           <= start_y;
        target_x        <= end_x;
        target_y        <= end_y;
        delta_x         <= load_dx;
        delta_y         <= load_dy;
        step_x_negative <= !(start_x < end_x);
        step_y_negative <= !(start_y < end_y);
        error_term      <= load_err;
        line_color      <= color;
        active          <= !flags.last;
      end else if (active) begin
        cur_x      <= step_x;
        cur_y      <= step_y;
        error_term <= err_step;
        active     <= !flags.last;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/line_pixel_generator.sv
// ----------------------------------------------------------------------------
// Line pixel generator
// Bresenham line walker with per-point screen clipping.
// ----------------------------------------------------------------------------
// Items enter on the s_ stream: tuser selects load (0) or step (1), tdata
// carries the endpoints and color, which a step ignores. Every transfer in
// gives exactly one point on the m_ stream; tlast marks the end point of the
// line, tuser bit 0 says the point is on screen, bit 1 that a line was busy.
// A step with no line in progress returns an all-zero point.
// The screen size is set through cfg_we, cfg_index and cfg_data while idle,
// a rule for the user that the block itself does not enforce. An item goes
// through an input register and an output register. One item per cycle is
// sustained while m_tready stays high; the walker's error update sits
// between these two registers. When the receiver stalls, the output holds,
// the input register fills and then s_tready drops. Reset empties both
// registers, ends any line and restores the screen size to 320 by 200.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_generator #(
  parameter int COORD_BITS = 16
) (
  input  wire                                         clk,
  input  wire                                         rst,
  input  wire                                         s_tvalid,
  output logic                                        s_tready,
  // start_x, start_y, end_x, end_y, color, zero fill
  input  wire  [((4*COORD_BITS+8+7)/8)*8-1:0]         s_tdata,
  // action
  input  wire  [0:0]                                  s_tuser,
  output logic                                        m_tvalid,
  input  wire                                         m_tready,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [((2*COORD_BITS+8+7)/8)*8-1:0]         m_tdata,
  // write_enable, line_busy
  output logic [1:0]                                  m_tuser,
  output logic                                        m_tlast,
  input  wire                                         cfg_we,
  input  wire  [0:0]                                  cfg_index,
  input  wire  [lpg_pkg::CFG_W-1:0]                   cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int IN_W  = ((4*COORD_BITS+8+7)/8)*8;
  localparam int OUT_W = ((2*COORD_BITS+8+7)/8)*8;
  localparam int CW    = ((COORD_BITS > lpg_pkg::CFG_W) ? COORD_BITS : lpg_pkg::CFG_W) + 1;

  logic [lpg_pkg::CFG_W-1:0] screen_width;
  logic [lpg_pkg::CFG_W-1:0] screen_height;

  logic            in_valid;
  logic [IN_W-1:0] in_data;
  logic [0:0]      in_action;
  logic            advance;

  logic signed [C-1:0]   pixel_x;
  logic signed [C-1:0]   pixel_y;
  logic [7:0]            pixel_color;
  lpg_pkg::point_flags_t flags;
  logic                  on_screen;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lpg_pkg::SCREEN_WIDTH_RESET;
      screen_height <= lpg_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lpg_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        lpg_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_data   <= s_tdata;
      in_action <= s_tuser;
    end
  end

  lpg_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .action     (in_action),
    .start_x    (in_data[C-1:0]),
    .start_y    (in_data[2*C-1:C]),
    .end_x      (in_data[3*C-1:2*C]),
    .end_y      (in_data[4*C-1:3*C]),
    .color      (in_data[4*C+7:4*C]),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_color(pixel_color),
    .flags      (flags)
  );

  always_comb begin
    on_screen = flags.busy
             && (CW'(pixel_x) >= $signed(CW'(0)))
             && (CW'(pixel_x) < $signed(CW'(screen_width)))
             && (CW'(pixel_y) >= $signed(CW'(0)))
             && (CW'(pixel_y) < $signed(CW'(screen_height)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= OUT_W'({pixel_color, pixel_y, pixel_x});
      m_tuser <= {flags.busy, on_screen};
      m_tlast <= flags.last;
    end
  end

  a_write_needs_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && !m_tuser[1]))
    else $error("on-screen point reported without an active line");

  a_last_needs_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1])
    else $error("end point reported without an active line");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed item did not reach the output register");

  a_held_item_stays: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_data))
    else $error("stalled input item was lost or changed");

endmodule

`default_nettype wire
